@@ src/tpq_pkg.sv @@
// tpq_pkg: shared types and default sizes for the task priority queue
// no dependencies; used by the cell and the top level
package tpq_pkg;

   // default sizes handed to the top level parameters
   localparam int unsigned DEPTH_DEF     = 16;
   localparam int unsigned TAG_BITS_DEF  = 8;
   localparam int unsigned PRIO_BITS_DEF = 8;

   // request kinds; codes 6 and 7 are ignored requests
   typedef enum logic [2:0] {
      KIND_APPEND = 3'd0,
      KIND_PUSH   = 3'd1,
      KIND_INSERT = 3'd2,
      KIND_POP    = 3'd3,
      KIND_REMOVE = 3'd4,
      KIND_PEEK   = 3'd5
   } kind_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic     update;
      kind_type kind;
   } cell_ctl_type;

endpackage

@@ src/tpq_ifs.sv @@
// tpq_ifs: request and response channel interfaces (valid / ready with payload)
// depends on nothing; widths come from interface parameters

// request channel
interface tpq_req_if #(
   parameter int unsigned TAG_BITS  = 8,
   parameter int unsigned PRIO_BITS = 8
);
   logic                 valid;
   logic                 ready;
   logic [2:0]           kind;
   logic [TAG_BITS-1:0]  task_tag;
   logic [PRIO_BITS-1:0] entry_priority;

   modport source (output valid, kind, task_tag, entry_priority, input ready);
   modport sink   (input valid, kind, task_tag, entry_priority, output ready);
endinterface

// response channel
interface tpq_rsp_if #(
   parameter int unsigned TAG_BITS  = 8,
   parameter int unsigned PRIO_BITS = 8,
   parameter int unsigned CNT_BITS  = 5
);
   logic                 valid;
   logic                 ready;
   logic [TAG_BITS-1:0]  out_tag;
   logic [PRIO_BITS-1:0] out_priority;
   logic [1:0]           status;
   logic [CNT_BITS-1:0]  entry_count;

   modport source (output valid, out_tag, out_priority, status, entry_count, input ready);
   modport sink   (input valid, out_tag, out_priority, status, entry_count, output ready);
endinterface

@@ src/tpq_cell.sv @@
// tpq_cell: one slot of the queue chain, holds a tag and a priority
// depends on tpq_pkg; neighbors pass insert-position and match chains through it
module tpq_cell #(
   parameter int unsigned TAG_BITS  = 8,
   parameter int unsigned PRIO_BITS = 8
) (
   input  logic                 clock,
   input  tpq_pkg::cell_ctl_type ctl,
   input  logic                 occupied,
   input  logic [TAG_BITS-1:0]  new_tag,
   input  logic [PRIO_BITS-1:0] new_prio,
   input  logic [TAG_BITS-1:0]  left_tag,
   input  logic [PRIO_BITS-1:0] left_prio,
   input  logic [TAG_BITS-1:0]  right_tag,
   input  logic [PRIO_BITS-1:0] right_prio,
   input  logic                 keep_in,
   output logic                 keep_out,
   input  logic                 found_in,
   output logic                 found_out,
   input  logic [PRIO_BITS-1:0] fprio_in,
   output logic [PRIO_BITS-1:0] fprio_out,
   output logic [TAG_BITS-1:0]  tag_q,
   output logic [PRIO_BITS-1:0] prio_q
);
   import tpq_pkg::*;

   logic [TAG_BITS-1:0]  tag_ff, tag_in;
   logic [PRIO_BITS-1:0] prio_ff, prio_in;
   logic                 stay_here;
   logic                 match_here;

   // insert: does the new entry go behind this slot
   always_comb begin
      case (ctl.kind)
         KIND_APPEND: stay_here = occupied;
         KIND_INSERT: stay_here = occupied && (prio_ff > new_prio);
         default:     stay_here = 1'b0;
      endcase
   end

   assign keep_out = keep_in && stay_here;

   // pop and remove: first slot that closes the gap
   always_comb begin
      case (ctl.kind)
         KIND_POP:    match_here = 1'b1;
         KIND_REMOVE: match_here = occupied && (tag_ff == new_tag);
         default:     match_here = 1'b0;
      endcase
   end

   assign found_out = found_in || match_here;
   assign fprio_out = found_in ? fprio_in : prio_ff;

   // next slot contents
   always_comb begin
      tag_in  = tag_ff;
      prio_in = prio_ff;
      if (ctl.kind inside {KIND_APPEND, KIND_PUSH, KIND_INSERT}) begin
         if (!keep_in) begin
            tag_in  = left_tag;
            prio_in = left_prio;
         end else if (!stay_here) begin
            tag_in  = new_tag;
            prio_in = new_prio;
         end
      end else if (ctl.kind inside {KIND_POP, KIND_REMOVE}) begin
         if (found_out) begin
            tag_in  = right_tag;
            prio_in = right_prio;
         end
      end
   end

   // slot storage, written only on an effective request
   always_ff @(posedge clock) begin
      if (ctl.update) begin
         tag_ff  <= tag_in;
         prio_ff <= prio_in;
      end
   end

   assign tag_q  = tag_ff;
   assign prio_q = prio_ff;

endmodule

@@ src/task_priority_queue.sv @@
// task_priority_queue: bounded ordered queue of task entries built as a row of cells
// depends on tpq_pkg, tpq_ifs (tpq_req_if, tpq_rsp_if) and tpq_cell
//
//   channel  dir  handshake      payload
//   req_if   in   valid / ready  kind, task_tag, entry_priority
//   rsp_if   out  valid / ready  out_tag, out_priority, status, entry_count
//
// one request per cycle; its response appears in the output register the cycle after.
// the whole update (position search along the chain plus shift) is combinational ahead of the slot write,
// so the longest path is the ripple through all DEPTH cells.
// a new request is taken while the response register is empty or being drained.
// synchronous reset empties the queue and drops any pending response; slot contents
// are not cleared, no clearing pass.
module task_priority_queue #(
   parameter int unsigned DEPTH     = tpq_pkg::DEPTH_DEF,
   parameter int unsigned TAG_BITS  = tpq_pkg::TAG_BITS_DEF,
   parameter int unsigned PRIO_BITS = tpq_pkg::PRIO_BITS_DEF
) (
   input logic clock,
   input logic reset,
   tpq_req_if.sink   req_if,
   tpq_rsp_if.source rsp_if
);
   import tpq_pkg::*;

   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 rsp_valid_ff;
   logic [TAG_BITS-1:0]  rsp_tag_ff, rsp_tag_in;
   logic [PRIO_BITS-1:0] rsp_prio_ff, rsp_prio_in;
   status_type           rsp_status_ff, rsp_status_in;

   logic                 accept;
   logic                 is_full, is_empty;
   kind_type             kind;
   cell_ctl_type         ctl;

   logic [DEPTH-1:0]     occupied;
   logic [DEPTH:0]       keep_chain;
   logic [DEPTH:0]       found_chain;
   logic [PRIO_BITS-1:0] fprio_chain [DEPTH+1];
   logic [TAG_BITS-1:0]  cell_tag  [DEPTH];
   logic [PRIO_BITS-1:0] cell_prio [DEPTH];

   // handshake
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign kind         = kind_type'(req_if.kind);
   assign is_full      = (count_ff == FULL_CNT);
   assign is_empty     = (count_ff == '0);

   // chain ends
   assign keep_chain[0]  = 1'b1;
   assign found_chain[0] = 1'b0;
   assign fprio_chain[0] = '0;

   // row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int unsigned LEFT  = (i == 0) ? 0 : i - 1;
      localparam int unsigned RIGHT = (i == DEPTH - 1) ? i : i + 1;

      assign occupied[i] = (count_ff > CNT_BITS'(i));

      tpq_cell #(
         .TAG_BITS  (TAG_BITS),
         .PRIO_BITS (PRIO_BITS)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (occupied[i]),
         .new_tag    (req_if.task_tag),
         .new_prio   (req_if.entry_priority),
         .left_tag   (cell_tag[LEFT]),
         .left_prio  (cell_prio[LEFT]),
         .right_tag  (cell_tag[RIGHT]),
         .right_prio (cell_prio[RIGHT]),
         .keep_in    (keep_chain[i]),
         .keep_out   (keep_chain[i+1]),
         .found_in   (found_chain[i]),
         .found_out  (found_chain[i+1]),
         .fprio_in   (fprio_chain[i]),
         .fprio_out  (fprio_chain[i+1]),
         .tag_q      (cell_tag[i]),
         .prio_q     (cell_prio[i])
      );
   end

   // request decode, response and count
   always_comb begin
      ctl.kind      = kind;
      ctl.update    = 1'b0;
      count_in      = count_ff;
      rsp_tag_in    = '0;
      rsp_prio_in   = '0;
      rsp_status_in = ST_OK;
      case (kind)
         KIND_APPEND, KIND_PUSH, KIND_INSERT: begin
            rsp_tag_in  = req_if.task_tag;
            rsp_prio_in = req_if.entry_priority;
            if (is_full) begin
               rsp_status_in = ST_FULL;
            end else begin
               ctl.update = accept;
               count_in   = count_ff + 1'b1;
            end
         end
         KIND_POP, KIND_PEEK: begin
            if (is_empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_tag_in  = cell_tag[0];
               rsp_prio_in = cell_prio[0];
               if (kind == KIND_POP) begin
                  ctl.update = accept;
                  count_in   = count_ff - 1'b1;
               end
            end
         end
         KIND_REMOVE: begin
            rsp_tag_in = req_if.task_tag;
            if (is_empty) begin
               rsp_status_in = ST_EMPTY;
            end else if (!found_chain[DEPTH]) begin
               rsp_status_in = ST_NOTFOUND;
            end else begin
               rsp_prio_in = fprio_chain[DEPTH];
               ctl.update  = accept;
               count_in    = count_ff - 1'b1;
            end
         end
         default: begin
            // unused codes: nothing changes
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_tag_ff    <= rsp_tag_in;
         rsp_prio_ff   <= rsp_prio_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.out_tag      = rsp_tag_ff;
   assign rsp_if.out_priority = rsp_prio_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.entry_count  = count_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above depth");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("transfer without response");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_FULL |-> count_ff == FULL_CNT)
      else $error("full status with free slots");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_EMPTY |-> count_ff == '0)
      else $error("empty status with entries held");

endmodule
